>>> hdl/ecsa_pkg.sv
`timescale 1ns / 1ps

package ecsa_pkg;

	// operation codes of a request
	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_ADD     = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	// status codes of a response
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_ENTITY = 3'd1,
		ST_NOT_LIVE  = 3'd2,
		ST_PRESENT   = 3'd3,
		ST_FULL      = 3'd4,
		ST_ABSENT    = 3'd5
	} status_t;

	localparam int unsigned HANDLE_W = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned SLOT_W   = 8;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [SLOT_W-1:0]   slot_t;

endpackage

>>> hdl/ecsa_req_if.sv
`timescale 1ns / 1ps

interface ecsa_req_if;
	import ecsa_pkg::*;

	logic    valid;
	logic    ready;
	op_t     operation;
	handle_t entity_handle;
	kind_t   component_kind;

	modport source (output valid, operation, entity_handle, component_kind, input ready);
	modport sink (input valid, operation, entity_handle, component_kind, output ready);
endinterface

>>> hdl/ecsa_rsp_if.sv
`timescale 1ns / 1ps

interface ecsa_rsp_if;
	import ecsa_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	handle_t new_entity;
	slot_t   slot;

	modport source (output valid, status, new_entity, slot, input ready);
	modport sink (input valid, status, new_entity, slot, output ready);
endinterface

>>> hdl/entity_component_slot_allocator_unit.sv
`timescale 1ns / 1ps

// channel | dir | payload                                   | handshake
// req     | in  | operation, entity_handle, component_kind  | valid/ready
// rsp     | out | status, new_entity, slot                  | valid/ready
//
// every request transaction has a read step and an update step: the accept edge
// launches the synchronous reads of the free stacks, slot table and present rows,
// and the commit edge does the update and loads the response register
// a new request is not taken until the previous one has done its update, since
// each operation reads state that the previous one just wrote
// arst_n clears depths, high marks, live bits and valid flags; memory
// contents are not cleared (present rows are only trusted under a live bit)
// a stalled response holds the update stage; a new request can still be
// accepted while the response register waits to be taken
module entity_component_slot_allocator_unit #(
	parameter int unsigned NUM_ENTITIES = 256,
	parameter int unsigned KIND_COUNT   = 4
) (
	input logic clk,
	input logic arst_n,
	ecsa_req_if.sink   req,
	ecsa_rsp_if.source rsp
);
	import ecsa_pkg::*;

	localparam int unsigned EW = $clog2(NUM_ENTITIES);
	localparam int unsigned DW = $clog2(NUM_ENTITIES + 1);
	localparam int unsigned KW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
	localparam logic [DW-1:0] FULL_DEPTH = DW'(NUM_ENTITIES);

	// control state
	logic [DW-1:0]           efd_q;          // entity free stack depth
	logic [DW-1:0]           ehm_q;          // entity high-water mark
	logic [DW-1:0]           sfd_q [KIND_COUNT];
	logic [DW-1:0]           shm_q [KIND_COUNT];
	logic [NUM_ENTITIES-1:0] live_q;

	// stage 1: request held while the memory reads land
	logic          valid_s1;
	op_t           op_s1;
	logic [EW-1:0] h_s1;
	logic          hok_s1;
	logic [KW-1:0] kidx_s1;
	logic          kok_s1;

	// registered memory read data
	logic [EW-1:0]         ef_rd_s1;
	logic [KIND_COUNT-1:0] pres_rd_s1;
	logic [EW-1:0]         soe_rd_s1 [KIND_COUNT];
	logic [EW-1:0]         sf_rd_s1 [KIND_COUNT];

	// response register
	logic    rsp_valid_q;
	status_t status_q;
	handle_t new_entity_q;
	slot_t   slot_q;

	logic          accept;
	logic          commit;
	logic [EW-1:0] h_in;

	assign req.ready = !valid_s1;
	assign accept    = req.valid && !valid_s1;
	assign commit    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign h_in      = EW'(req.entity_handle);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.new_entity = new_entity_q;
	assign rsp.slot       = slot_q;

	// update logic results
	status_t               status_d;
	logic [EW-1:0]         ent_d;
	logic [EW-1:0]         slot_d;
	logic [DW-1:0]         efd_d;
	logic [DW-1:0]         ehm_d;
	logic [DW-1:0]         sfd_d [KIND_COUNT];
	logic [DW-1:0]         shm_d [KIND_COUNT];
	logic                  live_set;
	logic                  live_clr;
	logic [EW-1:0]         live_idx;
	logic                  ef_we;
	logic [EW-1:0]         ef_wa;
	logic                  pres_we;
	logic [EW-1:0]         pres_wa;
	logic [KIND_COUNT-1:0] pres_wd;
	logic [KIND_COUNT-1:0] soe_we;
	logic [KIND_COUNT-1:0] sf_we;
	logic [EW-1:0]         sf_wa [KIND_COUNT];
	logic                  live_s;

	assign live_s = hok_s1 && live_q[h_s1];

	always_comb begin
		status_d = ST_OK;
		ent_d    = '0;
		slot_d   = '0;
		efd_d    = efd_q;
		ehm_d    = ehm_q;
		live_set = 1'b0;
		live_clr = 1'b0;
		live_idx = h_s1;
		ef_we    = 1'b0;
		ef_wa    = EW'(efd_q);
		pres_we  = 1'b0;
		pres_wa  = h_s1;
		pres_wd  = '0;
		soe_we   = '0;
		sf_we    = '0;
		for (int k = 0; k < KIND_COUNT; k++) begin
			sfd_d[k] = sfd_q[k];
			shm_d[k] = shm_q[k];
			sf_wa[k] = EW'(sfd_q[k]);
		end
		unique case (op_s1)
			OP_CREATE: begin
				// pop a recycled handle first, else take a fresh one
				if (efd_q != '0) begin
					efd_d    = efd_q - 1'b1;
					live_set = 1'b1;
					live_idx = ef_rd_s1;
				end else if (ehm_q < FULL_DEPTH) begin
					ehm_d    = ehm_q + 1'b1;
					live_set = 1'b1;
					live_idx = EW'(ehm_q);
				end else begin
					status_d = ST_NO_ENTITY;
				end
				if (live_set) begin
					pres_we = 1'b1;
					pres_wa = live_idx;
					ent_d   = live_idx;
				end
			end
			OP_DESTROY: begin
				if (!live_s) begin
					status_d = ST_NOT_LIVE;
				end else begin
					// every held slot goes back onto its own kind's stack unless that stack is full
					for (int k = 0; k < KIND_COUNT; k++) begin
						if (pres_rd_s1[k] && sfd_q[k] < FULL_DEPTH) begin
							sf_we[k] = 1'b1;
							sfd_d[k] = sfd_q[k] + 1'b1;
						end
					end
					pres_we  = 1'b1;
					live_clr = 1'b1;
					if (efd_q < FULL_DEPTH) begin
						ef_we = 1'b1;
						efd_d = efd_q + 1'b1;
					end
				end
			end
			OP_ADD: begin
				if (!live_s) begin
					status_d = ST_NOT_LIVE;
				end else if (!kok_s1) begin
					status_d = ST_FULL;
				end else if (pres_rd_s1[kidx_s1]) begin
					status_d = ST_PRESENT;
				end else if (sfd_q[kidx_s1] != '0) begin
					sfd_d[kidx_s1]  = sfd_q[kidx_s1] - 1'b1;
					slot_d          = sf_rd_s1[kidx_s1];
					soe_we[kidx_s1] = 1'b1;
				end else if (shm_q[kidx_s1] < FULL_DEPTH) begin
					shm_d[kidx_s1]  = shm_q[kidx_s1] + 1'b1;
					slot_d          = EW'(shm_q[kidx_s1]);
					soe_we[kidx_s1] = 1'b1;
				end else begin
					status_d = ST_FULL;
				end
				if (soe_we != '0) begin
					pres_we = 1'b1;
					pres_wd = pres_rd_s1 | (KIND_COUNT'(1) << kidx_s1);
				end
			end
			OP_LOOKUP: begin
				// present row is only meaningful under a live bit
				if (live_s && kok_s1 && pres_rd_s1[kidx_s1]) begin
					slot_d = soe_rd_s1[kidx_s1];
				end else begin
					status_d = ST_ABSENT;
				end
			end
			default: begin
				status_d = ST_ABSENT;
			end
		endcase
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.operation;
			h_s1    <= h_in;
			hok_s1  <= 32'(req.entity_handle) < NUM_ENTITIES;
			kidx_s1 <= KW'(req.component_kind);
			kok_s1  <= 32'(req.component_kind) < KIND_COUNT;
		end
	end

	// allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			efd_q  <= '0;
			ehm_q  <= '0;
			live_q <= '0;
			for (int k = 0; k < KIND_COUNT; k++) begin
				sfd_q[k] <= '0;
				shm_q[k] <= '0;
			end
		end else if (commit) begin
			efd_q <= efd_d;
			ehm_q <= ehm_d;
			for (int k = 0; k < KIND_COUNT; k++) begin
				sfd_q[k] <= sfd_d[k];
				shm_q[k] <= shm_d[k];
			end
			if (live_set) begin
				live_q[live_idx] <= 1'b1;
			end else if (live_clr) begin
				live_q[live_idx] <= 1'b0;
			end
		end
	end

	// entity free stack and present rows
	logic [EW-1:0]         ef_mem [NUM_ENTITIES];
	logic [KIND_COUNT-1:0] pres_mem [NUM_ENTITIES];

	always_ff @(posedge clk) begin
		if (commit && ef_we) begin
			ef_mem[ef_wa] <= h_s1;
		end
		if (accept) begin
			ef_rd_s1 <= ef_mem[EW'(efd_q - 1'b1)];
		end
	end

	always_ff @(posedge clk) begin
		if (commit && pres_we) begin
			pres_mem[pres_wa] <= pres_wd;
		end
		if (accept) begin
			pres_rd_s1 <= pres_mem[h_in];
		end
	end

	// one slot table and one slot free stack per component kind
	for (genvar g = 0; g < KIND_COUNT; g++) begin : g_kind
		logic [EW-1:0] soe_mem [NUM_ENTITIES];
		logic [EW-1:0] sf_mem [NUM_ENTITIES];

		always_ff @(posedge clk) begin
			if (commit && soe_we[g]) begin
				soe_mem[h_s1] <= slot_d;
			end
			if (accept) begin
				soe_rd_s1[g] <= soe_mem[h_in];
			end
		end

		always_ff @(posedge clk) begin
			if (commit && sf_we[g]) begin
				sf_mem[sf_wa[g]] <= soe_rd_s1[g];
			end
			if (accept) begin
				sf_rd_s1[g] <= sf_mem[EW'(sfd_q[g] - 1'b1)];
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			new_entity_q <= HANDLE_W'(ent_d);
			slot_q       <= SLOT_W'(slot_d);
		end
	end

endmodule
